// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 16;
    localparam int OCC_W         = 5;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;  // -1 on empty remove

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                      mode;
        logic signed [VALUE_W-1:0]  item_value;
        logic signed [RANK_W-1:0]   rank;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  out_value;
        logic [OCC_W-1:0]           occupancy;
    } out_item_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
        logic signed [RANK_W-1:0]   rank;
    } cell_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell
(
    input  logic                               clk,
    input  spq_pkg::cell_cmd_t                 cmd,
    input  logic                               occupied,
    input  logic                               left_place,
    input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
    input  logic signed [spq_pkg::RANK_W-1:0]  left_rank,
    input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
    input  logic signed [spq_pkg::RANK_W-1:0]  right_rank,
    output logic                               place,
    output logic signed [spq_pkg::VALUE_W-1:0] value,
    output logic signed [spq_pkg::RANK_W-1:0]  rank
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;
    logic signed [spq_pkg::RANK_W-1:0]  rank_reg;
    logic signed [spq_pkg::RANK_W-1:0]  rank_next;

    // new entry lands at the first slot that is free or holds a strictly larger rank
    assign place = !occupied || (rank_reg > cmd.rank);

    always_comb
    begin
        value_next = value_reg;
        rank_next  = rank_reg;
        priority if (cmd.rem)
        begin
            value_next = right_value;
            rank_next  = right_rank;
        end
        else if (cmd.ins && left_place)
        begin
            // shift right behind the insertion point
            value_next = left_value;
            rank_next  = left_rank;
        end
        else if (cmd.ins && place)
        begin
            value_next = cmd.value;
            rank_next  = cmd.rank;
        end
        else
        begin
            value_next = value_reg;
            rank_next  = rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rank_reg  <= rank_next;
    end

    assign value = value_reg;
    assign rank  = rank_reg;

endmodule

// ----- rtl/stable_priority_queue_top.sv -----
`timescale 1ns / 1ps
// A transfer accepted at one edge shows its result, with done high, in the next cycle.
// One request per cycle; busy stays low, every cell compares and shifts in parallel.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
// Reset (rst_n low, asynchronous) empties the queue and clears done; no clearing pass,
// entry storage is only read below the count.

module stable_priority_queue_top
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  spq_pkg::in_item_t   in_item,
    output logic                done,
    output spq_pkg::out_item_t  result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    spq_pkg::out_item_t result_reg;
    spq_pkg::out_item_t result_next;

    logic               accept;
    logic               full;
    logic               empty;
    spq_pkg::cell_cmd_t cmd;

    logic                               cell_place [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic signed [spq_pkg::RANK_W-1:0]  cell_rank  [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        cmd.ins   = accept && (in_item.mode == spq_pkg::MODE_INSERT) && !full;
        cmd.rem   = accept && (in_item.mode == spq_pkg::MODE_REMOVE) && !empty;
        cmd.value = in_item.item_value;
        cmd.rank  = in_item.rank;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                               lp;
            logic signed [spq_pkg::VALUE_W-1:0] lv;
            logic signed [spq_pkg::RANK_W-1:0]  lr;
            logic signed [spq_pkg::VALUE_W-1:0] rv;
            logic signed [spq_pkg::RANK_W-1:0]  rr;

            if (gi == 0)
            begin : g_first
                assign lp = 1'b0;
                assign lv = '0;
                assign lr = '0;
            end
            else
            begin : g_mid
                assign lp = cell_place[gi-1];
                assign lv = cell_value[gi-1];
                assign lr = cell_rank[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign rv = '0;
                assign rr = '0;
            end
            else
            begin : g_body
                assign rv = cell_value[gi+1];
                assign rr = cell_rank[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (CNT_W'(gi) < count_reg),
                .left_place  (lp),
                .left_value  (lv),
                .left_rank   (lr),
                .right_value (rv),
                .right_rank  (rr),
                .place       (cell_place[gi]),
                .value       (cell_value[gi]),
                .rank        (cell_rank[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        if (accept)
        begin
            unique case (in_item.mode)
                spq_pkg::MODE_INSERT:
                begin
                    result_next.out_value = '0;
                    if (full)
                    begin
                        result_next.status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        result_next.status = spq_pkg::ST_OK;
                        count_next         = count_reg + 1'b1;
                    end
                end
                spq_pkg::MODE_REMOVE:
                begin
                    if (empty)
                    begin
                        result_next.status    = spq_pkg::ST_EMPTY;
                        result_next.out_value = spq_pkg::EMPTY_VALUE;
                    end
                    else
                    begin
                        result_next.status    = spq_pkg::ST_OK;
                        result_next.out_value = cell_value[0];
                        count_next            = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    result_next = result_reg;
                end
            endcase
            result_next.occupancy = spq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds depth");

    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after transfer");

    a_empty_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::ST_EMPTY) |-> (result.occupancy == '0))
        else $error("empty remove with nonzero occupancy");

    a_remove_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("remove did not decrement count");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_rank[0] <= cell_rank[1]))
        else $error("head entries out of rank order");

endmodule

// ----- tb/tb_stable_priority_queue_top.sv -----
`timescale 1ns / 1ps

module tb_stable_priority_queue_top;
    import spq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 490;

    class queue_model;
        logic signed [VALUE_W-1:0] values [QDEPTH];
        logic signed [RANK_W-1:0]  ranks [QDEPTH];
        int                        count = 0;
        out_item_t                 expected_results [$];
        int                        mismatches = 0;

        // Sorted insert after equal ranks, head removal, one result per request
        function void note_request(in_item_t req);
            out_item_t res;
            int        pos;
            res.status    = ST_OK;
            res.out_value = '0;
            if (req.mode == MODE_INSERT) begin
                if (count >= QDEPTH) begin
                    res.status = ST_FULL;
                end
                else begin
                    pos = 0;
                    while (pos < count && $signed(ranks[pos]) <= $signed(req.rank))
                        pos++;
                    for (int i = count; i > pos; i--) begin
                        values[i] = values[i-1];
                        ranks[i]  = ranks[i-1];
                    end
                    values[pos] = req.item_value;
                    ranks[pos]  = req.rank;
                    count++;
                end
            end
            else if (count == 0) begin
                res.status    = ST_EMPTY;
                res.out_value = EMPTY_VALUE;
            end
            else begin
                res.out_value = values[0];
                for (int i = 1; i < count; i++) begin
                    values[i-1] = values[i];
                    ranks[i-1]  = ranks[i];
                end
                count--;
            end
            res.occupancy = OCC_W'(count);
            expected_results.push_back(res);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result", '0, got.out_value);
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status)
                report("status", want.status, got.status);
            if (got.out_value != want.out_value)
                report("out_value", want.out_value, got.out_value);
            if (got.occupancy != want.occupancy)
                report("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    in_item_t   in_item = '0;
    logic       done;
    out_item_t  result;

    queue_model model = new;
    int         cycles = 0;
    int         idle_pct = 0;

    stable_priority_queue_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                model.note_request(in_item);
            if (done)
                model.check_result(result);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic in_item_t make_insert(logic [31:0] v, logic [15:0] r);
        in_item_t req;
        req.mode       = MODE_INSERT;
        req.item_value = v;
        req.rank       = r;
        return req;
    endfunction

    function automatic in_item_t make_remove();
        in_item_t req;
        req.mode       = MODE_REMOVE;
        req.item_value = $urandom;
        req.rank       = RANK_W'($urandom);
        return req;
    endfunction

    // Narrow ranks most of the time so that ties are common
    function automatic in_item_t random_request(int insert_pct);
        in_item_t req;
        req.mode       = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
        req.item_value = $urandom;
        case ($urandom_range(3))
            0:       req.rank = RANK_W'($urandom);
            1:       req.rank = RANK_W'($urandom_range(3));
            2:       req.rank = RANK_W'($urandom_range(4)) - 16'sd2;
            default: req.rank = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
        return req;
    endfunction

    // start stays high across back-to-back transfers; only lowered for a gap
    task automatic issue(in_item_t req);
        start   <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start   <= 1'b0;
            in_item <= random_request($urandom_range(99));
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (model.expected_results.size() != 0);
    endtask

    initial begin
        int insert_pct;
        int phase_idle [3];

        phase_idle = '{0, 47, 9};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty remove, extreme values and ranks, ties at both rank ends, full insert
        issue(make_remove());
        issue(make_insert(32'h7fffffff, 16'sd0));
        issue(make_insert(32'h80000000, 16'sd0));
        issue(make_insert(32'hffffffff, 16'sh8000));
        issue(make_insert(32'h00000000, 16'sh7fff));
        issue(make_insert(32'h00000001, 16'sh7fff));
        issue(make_insert(32'h00000002, 16'sh8000));
        repeat (QDEPTH - 6)
            issue(make_insert($urandom, RANK_W'($urandom_range(2))));
        issue(make_insert(32'h12345678, 16'sh8000));
        repeat (3)
            issue(make_remove());
        wait_for_results();

        foreach (phase_idle[p]) begin
            idle_pct   = phase_idle[p];
            insert_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // bursts lean toward filling or draining so both ends get hit
                if (n % 40 == 0)
                    case ($urandom_range(2))
                        0:       insert_pct = 25;
                        1:       insert_pct = 50;
                        default: insert_pct = 80;
                    endcase
                issue(random_request(insert_pct));
            end
            wait_for_results();
        end

        repeat (5) @(posedge clk);
        if (model.mismatches == 0 && model.expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
